// ===== hdl/keyed_account_table_with_history_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the keyed account table.
// The macros assume a clock named clk and an active-low reset named rst_n.
// ---------------------------------------------------------------------------
`ifndef KEYED_ACCOUNT_TABLE_WITH_HISTORY_ASSERT_SVH
`define KEYED_ACCOUNT_TABLE_WITH_HISTORY_ASSERT_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define KATH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that cons holds in the cycle after ante.
`define KATH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KATH_ASSERT_SAME(label, ante, cons, msg)
`define KATH_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hdl/kath_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kath_pkg
// Field widths, action and status codes, and the history entry layout.
// ---------------------------------------------------------------------------
package kath_pkg;

  localparam int UID_W   = 40;
  localparam int AMT_W   = 32;
  localparam int SEQ_W   = 32;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;
  localparam int ISLOT_W = 4;
  localparam int OSLOT_W = 4;
  localparam int OCNT_W  = 4;
  localparam int HIDX_W  = 8;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CREATE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [AMT_W-1:0] amount;
    logic [SEQ_W-1:0] seq;
  } hist_ent_t;

endpackage : kath_pkg
`default_nettype wire

// ===== hdl/kath_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kath_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module kath_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule : kath_ram
`default_nettype wire

// ===== hdl/keyed_account_table_with_history.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each item passes IDLE, DISPATCH, then SCAN (lookup, create) or SLOT_USE (add, read
// history, then HIST_RD for an in-range index), then DONE, which waits for a free output
// register. Clear, unknown actions and add or read on an empty slot skip to DONE. The scan
// reads one slot entry per cycle and stops at a key match. One item is in work at a time;
// in_stall is high until the result is loaded. Reset (synchronous, rst_n low) clears the
// slot valid bits and sets the sequence counter to one; the memories need no clearing pass.
// ---------------------------------------------------------------------------
// keyed_account_table_with_history
// Card slot table keyed by a 40-bit uid, with balance and a ring of recent transactions.
// ---------------------------------------------------------------------------
`include "keyed_account_table_with_history_assert.svh"

module keyed_account_table_with_history
  import kath_pkg::*;
#(
  parameter int CARD_SLOTS    = 16,
  parameter int HISTORY_DEPTH = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic        [ACT_W-1:0]   in_action,
  input  wire logic        [UID_W-1:0]   in_card_uid,
  input  wire logic        [ISLOT_W-1:0] in_slot_index,
  input  wire logic signed [AMT_W-1:0]   in_amount,
  input  wire logic        [HIDX_W-1:0]  in_history_index,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic             [STAT_W-1:0]  out_status,
  output logic             [OSLOT_W-1:0] out_result_slot,
  output logic signed      [AMT_W-1:0]   out_balance,
  output logic             [OCNT_W-1:0]  out_history_count,
  output logic signed      [AMT_W-1:0]   out_tx_amount,
  output logic             [SEQ_W-1:0]   out_tx_sequence
);

  localparam int SLOT_W  = (CARD_SLOTS > 1) ? $clog2(CARD_SLOTS) : 1;
  localparam int SCNT_W  = $clog2(CARD_SLOTS + 1);
  localparam int HEAD_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int HDEPTH  = CARD_SLOTS * HISTORY_DEPTH;
  localparam int HADDR_W = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int POS_W   = 10;

  localparam logic [SCNT_W-1:0]  SLOTS_CNT  = SCNT_W'(CARD_SLOTS);
  localparam logic [HEAD_W-1:0]  HEAD_LAST  = HEAD_W'(HISTORY_DEPTH - 1);
  localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(HISTORY_DEPTH);
  localparam logic [HADDR_W-1:0] HDEPTH_A   = HADDR_W'(HISTORY_DEPTH);
  localparam logic [POS_W-1:0]   HDEPTH_P   = POS_W'(HISTORY_DEPTH);
  localparam logic [POS_W-1:0]   HDEPTH_M1  = POS_W'(HISTORY_DEPTH - 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_SLOT_USE = 3'd3;
  localparam logic [2:0] ST_HIST_RD  = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  typedef struct packed {
    logic [UID_W-1:0]  key;
    logic [AMT_W-1:0]  balance;
    logic [HEAD_W-1:0] head;
    logic [FILL_W-1:0] fill;
  } slot_ent_t;

  logic [2:0]            state_r;
  logic [2:0]            state_nxt;
  logic [CARD_SLOTS-1:0] valid_r;
  logic [SEQ_W-1:0]      next_seq_r;

  // Latched item
  logic [ACT_W-1:0]   act_r;
  logic [UID_W-1:0]   uid_r;
  logic [ISLOT_W-1:0] slot_r;
  logic [AMT_W-1:0]   amt_r;
  logic [HIDX_W-1:0]  hidx_r;

  // Scan pipeline
  logic [SCNT_W-1:0]  scan_cnt_r;
  logic               chk_en_r;
  logic [SLOT_W-1:0]  chk_idx_r;
  logic               free_found_r;
  logic [SLOT_W-1:0]  free_idx_r;

  // Result being built, then the output register
  logic [STAT_W-1:0]  res_status_r;
  logic [OSLOT_W-1:0] res_slot_r;
  logic [AMT_W-1:0]   res_bal_r;
  logic [OCNT_W-1:0]  res_cnt_r;
  logic [AMT_W-1:0]   res_amt_r;
  logic [SEQ_W-1:0]   res_seq_r;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [OSLOT_W-1:0] out_slot_r;
  logic [AMT_W-1:0]   out_bal_r;
  logic [OCNT_W-1:0]  out_cnt_r;
  logic [AMT_W-1:0]   out_amt_r;
  logic [SEQ_W-1:0]   out_seq_r;

  // Memory ports
  logic               slot_we;
  logic [SLOT_W-1:0]  slot_waddr;
  slot_ent_t          slot_wdata;
  logic [SLOT_W-1:0]  slot_raddr;
  slot_ent_t          slot_rd;
  logic               hist_we;
  logic [HADDR_W-1:0] hist_waddr;
  hist_ent_t          hist_wdata;
  logic [HADDR_W-1:0] hist_raddr;
  hist_ent_t          hist_rd;

  // Datapath
  logic [SLOT_W-1:0]  slot_sel;
  logic               slot_ok;
  logic               scan_issue;
  logic               scan_hit;
  logic               scan_end;
  logic               out_free;
  logic [AMT_W-1:0]   bal_sum;
  logic [HEAD_W-1:0]  head_nxt;
  logic [FILL_W-1:0]  fill_nxt;
  logic               hidx_beyond;
  logic [POS_W-1:0]   pos_raw;
  logic [HEAD_W-1:0]  pos;
  logic [HADDR_W-1:0] hist_base;

  kath_ram #(
    .WIDTH ($bits(slot_ent_t)),
    .DEPTH (CARD_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_addr (slot_raddr),
    .rd_data (slot_rd)
  );

  kath_ram #(
    .WIDTH ($bits(hist_ent_t)),
    .DEPTH (HDEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (hist_waddr),
    .wr_data (hist_wdata),
    .rd_addr (hist_raddr),
    .rd_data (hist_rd)
  );

  assign slot_sel = SLOT_W'(slot_r);
  assign slot_ok  = (9'(slot_r) < 9'(CARD_SLOTS)) && valid_r[slot_sel];
  assign out_free = !out_valid_r || !out_stall;

  assign scan_issue = (scan_cnt_r < SLOTS_CNT);
  assign scan_hit   = chk_en_r && valid_r[chk_idx_r] && (slot_rd.key == uid_r);
  assign scan_end   = !chk_en_r && !scan_issue;

  assign bal_sum  = slot_rd.balance + amt_r;
  assign head_nxt = (slot_rd.head == HEAD_LAST) ? '0 : slot_rd.head + 1'b1;
  assign fill_nxt = (slot_rd.fill < FILL_FULL) ? slot_rd.fill + 1'b1 : slot_rd.fill;

  // Walk back from the entry just before the head; hidx is below the fill count here.
  assign hidx_beyond = (9'(hidx_r) >= 9'(slot_rd.fill));
  assign pos_raw     = POS_W'(slot_rd.head) + HDEPTH_M1 - POS_W'(hidx_r);
  assign pos         = (pos_raw >= HDEPTH_P) ? HEAD_W'(pos_raw - HDEPTH_P) : HEAD_W'(pos_raw);
  assign hist_base   = HADDR_W'(slot_sel) * HDEPTH_A;

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot_sel;
    slot_wdata = '{key: slot_rd.key, balance: bal_sum, head: head_nxt, fill: fill_nxt};
    slot_raddr = (state_r == ST_SCAN) ? scan_cnt_r[SLOT_W-1:0] : slot_sel;
    hist_we    = 1'b0;
    hist_waddr = hist_base + HADDR_W'(slot_rd.head);
    hist_wdata = '{amount: amt_r, seq: next_seq_r};
    hist_raddr = hist_base + HADDR_W'(pos);
    case (state_r)
      ST_SCAN: begin
        if (scan_end && (act_r == ACT_CREATE) && free_found_r) begin
          slot_we    = 1'b1;
          slot_waddr = free_idx_r;
          slot_wdata = '{key: uid_r, balance: '0, head: '0, fill: '0};
        end
      end
      ST_SLOT_USE: begin
        if (act_r == ACT_ADD) begin
          slot_we = 1'b1;
          hist_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (act_r)
          ACT_LOOKUP, ACT_CREATE: state_nxt = ST_SCAN;
          ACT_ADD, ACT_READ:      state_nxt = slot_ok ? ST_SLOT_USE : ST_DONE;
          default:                state_nxt = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SLOT_USE: begin
        state_nxt = ((act_r == ACT_READ) && !hidx_beyond) ? ST_HIST_RD : ST_DONE;
      end
      ST_HIST_RD: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      next_seq_r   <= SEQ_W'(1);
      out_valid_r  <= 1'b0;
      chk_en_r     <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Drop the taken item unless a new result loads in this cycle
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            act_r  <= in_action;
            uid_r  <= in_card_uid;
            slot_r <= in_slot_index;
            amt_r  <= $unsigned(in_amount);
            hidx_r <= in_history_index;
          end
        end
        ST_DISPATCH: begin
          res_status_r <= STAT_OK;
          res_slot_r   <= '0;
          res_bal_r    <= '0;
          res_cnt_r    <= '0;
          res_amt_r    <= '0;
          res_seq_r    <= '0;
          scan_cnt_r   <= '0;
          chk_en_r     <= 1'b0;
          free_found_r <= 1'b0;
          case (act_r)
            ACT_CLEAR: begin
              valid_r    <= '0;
              next_seq_r <= SEQ_W'(1);
            end
            ACT_ADD, ACT_READ: begin
              res_slot_r <= slot_r;
              if (!slot_ok) begin
                res_status_r <= STAT_NONE;
              end
            end
            default: ;
          endcase
        end
        ST_SCAN: begin
          // Remember the first empty slot seen for a create
          if (chk_en_r && !valid_r[chk_idx_r] && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= chk_idx_r;
          end
          if (scan_issue) begin
            chk_en_r   <= 1'b1;
            chk_idx_r  <= scan_cnt_r[SLOT_W-1:0];
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end else begin
            chk_en_r <= 1'b0;
          end
          if (scan_hit) begin
            res_slot_r <= OSLOT_W'(chk_idx_r);
            res_bal_r  <= slot_rd.balance;
            res_cnt_r  <= OCNT_W'(slot_rd.fill);
          end else if (scan_end) begin
            if ((act_r == ACT_CREATE) && free_found_r) begin
              valid_r[free_idx_r] <= 1'b1;
              res_slot_r          <= OSLOT_W'(free_idx_r);
            end else if (act_r == ACT_CREATE) begin
              res_status_r <= STAT_FULL;
            end else begin
              res_status_r <= STAT_NONE;
            end
          end
        end
        ST_SLOT_USE: begin
          if (act_r == ACT_ADD) begin
            next_seq_r <= next_seq_r + 1'b1;
            res_bal_r  <= bal_sum;
            res_cnt_r  <= OCNT_W'(fill_nxt);
            res_amt_r  <= amt_r;
            res_seq_r  <= next_seq_r;
          end else begin
            res_bal_r <= slot_rd.balance;
            res_cnt_r <= OCNT_W'(slot_rd.fill);
            if (hidx_beyond) begin
              res_status_r <= STAT_RANGE;
            end
          end
        end
        ST_HIST_RD: begin
          res_amt_r <= hist_rd.amount;
          res_seq_r <= hist_rd.seq;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= res_slot_r;
            out_bal_r    <= res_bal_r;
            out_cnt_r    <= res_cnt_r;
            out_amt_r    <= res_amt_r;
            out_seq_r    <= res_seq_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_slot   = out_slot_r;
  assign out_balance       = $signed(out_bal_r);
  assign out_history_count = out_cnt_r;
  assign out_tx_amount     = $signed(out_amt_r);
  assign out_tx_sequence   = out_seq_r;

  `KATH_ASSERT_SAME(a_hist_we_add, hist_we, (state_r == ST_SLOT_USE) && (act_r == ACT_ADD), "history write outside an add")
  `KATH_ASSERT_NEXT(a_clear_all, (state_r == ST_DISPATCH) && (act_r == ACT_CLEAR), (valid_r == '0) && (next_seq_r == SEQ_W'(1)), "clear did not reset table")
  `KATH_ASSERT_SAME(a_scan_idx, chk_en_r, 9'(chk_idx_r) < 9'(CARD_SLOTS), "scan index beyond table")
  `KATH_ASSERT_SAME(a_fill_max, state_r == ST_SLOT_USE, 9'(slot_rd.fill) <= 9'(HISTORY_DEPTH), "ring fill beyond depth")

endmodule : keyed_account_table_with_history
`default_nettype wire
